/* rtl/core/sha256_pkg.sv */
// shared types, constants and round table for the sha-256 stream hasher
package sha256_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       init;       // restart message state
        logic       wr_byte;    // write input byte into buffer
        logic       wr_pad;     // write pad byte (0x80 or zero) at fill
        logic       pad_first;  // pad byte is 0x80
        logic       wr_len;     // write length bytes 56..63
        logic       comp_start; // load working vars and schedule
        logic       round;      // run one round
        logic       add;        // fold working vars into chain
        logic       out_shift;  // rotate chain for output
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [5:0] fill;
        logic       fill_wrap;  // fill is 63 (block full after write)
        logic [5:0] round_idx;
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* rtl/core/sha256_datapath.sv */
// sha-256 datapath: block buffer, schedule window, rounds, chain words
module sha256_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_cmd     i_cmd,
    input  logic [7:0]           i_data_byte,
    output sha256_pkg::t_status  o_status,
    output logic [31:0]          o_digest_word
);
    import sha256_pkg::*;

    logic [31:0] r_block [16];
    logic [31:0] n_block [16];
    logic [31:0] r_w [16];
    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;

    logic [7:0]  wr_data;
    logic        wr_en;
    logic [31:0] w_new, w_cur, s0, s1, t1, t2, sig0, sig1, ch, maj;

    assign wr_en   = i_cmd.wr_byte | i_cmd.wr_pad;
    assign wr_data = i_cmd.wr_byte ? i_data_byte :
                     (i_cmd.pad_first ? PAD_BYTE : 8'h00);

    // schedule word for this round
    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = (r_round < 6'd16) ? r_w[0] : w_new;
    end

    // round function
    always_comb begin
        sig1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + sig1 + ch + ROUND_K[r_round] + w_cur;
        sig0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = sig0 + maj;
    end

    // buffer contents with this cycle's byte or length write applied
    always_comb begin
        n_block = r_block;
        if (wr_en) begin
            unique case (r_fill[1:0])
                2'd0: n_block[r_fill[5:2]][31:24] = wr_data;
                2'd1: n_block[r_fill[5:2]][23:16] = wr_data;
                2'd2: n_block[r_fill[5:2]][15:8]  = wr_data;
                default: n_block[r_fill[5:2]][7:0] = wr_data;
            endcase
        end else if (i_cmd.wr_len) begin
            n_block[14] = r_bits[63:32];
            n_block[15] = r_bits[31:0];
        end
    end

    // block buffer, held as big-endian words
    always_ff @(posedge i_clk) begin
        r_block <= n_block;
    end

    // fill, bit count and round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
        end else begin
            if (wr_en) r_fill <= r_fill + 6'd1;
            if (i_cmd.wr_len) r_fill <= '0;
            if (i_cmd.wr_byte) r_bits <= r_bits + 64'd8;
            if (i_cmd.comp_start) r_round <= '0;
            else if (i_cmd.round) r_round <= r_round + 6'd1;
        end
    end

    // schedule window rolls one word per round, loaded with the completed block
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_w <= n_block;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_v <= r_chain;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // chain words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_chain <= INIT_HASH;
        end else if (i_cmd.add) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
        end else if (i_cmd.out_shift) begin
            for (int i = 0; i < 7; i++) r_chain[i] <= r_chain[i+1];
            r_chain[7] <= r_chain[0];
        end
    end

    assign o_status.fill      = r_fill;
    assign o_status.fill_wrap = (r_fill == 6'd63);
    assign o_status.round_idx = r_round;
    assign o_digest_word      = r_chain[0];
endmodule

/* rtl/core/sha256_ctrl.sv */
// sha-256 controller: byte loading, padding, compression, digest output
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_byte_present,
    input  logic                 i_end_of_message,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word,
    output sha256_pkg::t_cmd     o_cmd,
    input  sha256_pkg::t_status  i_status
);
    import sha256_pkg::*;

    t_state     r_state, n_state;
    logic       r_final, n_final;   // compression belongs to final padding
    logic       r_len_done, n_len_done;
    logic [2:0] r_idx, n_idx;
    logic       acc;

    assign acc = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        n_len_done = r_len_done;
        n_idx      = r_idx;
        unique case (r_state)
            ST_LOAD: begin
                if (acc) begin
                    n_final    = i_end_of_message;
                    n_len_done = 1'b0;
                    if (i_byte_present && i_status.fill_wrap) n_state = ST_COMP;
                    else if (i_end_of_message) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                // writes 0x80 first, then zeros
                if (i_status.fill == 6'd63) n_state = ST_COMP;
                else if (i_status.fill == LEN_POS - 6'd1) n_state = ST_LEN;
            end
            ST_LEN: begin
                n_len_done = 1'b1;
                n_state    = ST_COMP;
            end
            ST_COMP: begin
                if (i_status.round_idx == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                if (!r_final) n_state = ST_LOAD;
                else if (r_len_done) begin
                    n_state = ST_OUT;
                    n_idx   = '0;
                end else n_state = ST_PAD;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // pad byte is 0x80 only on the first pad write after the message
    logic r_pad_first, n_pad_first;
    always_comb begin
        n_pad_first = r_pad_first;
        if (r_state == ST_LOAD && acc) n_pad_first = 1'b1;
        else if (r_state == ST_PAD) n_pad_first = 1'b0;
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.wr_byte = acc && i_byte_present;
            end
            ST_PAD: begin
                o_cmd.wr_pad    = 1'b1;
                o_cmd.pad_first = r_pad_first;
            end
            ST_LEN: o_cmd.wr_len = 1'b1;
            ST_COMP: o_cmd.round = 1'b1;
            ST_ADD: o_cmd.add = 1'b1;
            ST_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.out_shift = i_out_ready;
                o_cmd.init      = i_out_ready && (r_idx == 3'd7);
            end
            default: ;
        endcase
        o_cmd.comp_start = (r_state != ST_COMP) && (n_state == ST_COMP);
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_final     <= 1'b0;
            r_len_done  <= 1'b0;
            r_idx       <= '0;
            r_pad_first <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_len_done  <= n_len_done;
            r_idx       <= n_idx;
            r_pad_first <= n_pad_first;
        end
    end
endmodule

/* rtl/core/sha256_stream_hasher_top.sv */
// top level of the sha-256 stream hasher
// a byte item is taken while loading; the 64th byte of a block stalls input to compress
// (64 rounds of one shared round unit, then the chain add; schedule loads with the write)
// final item: up to 64 pad writes and one length write around one or two compressions,
// then eight digest items, one per cycle while the sink is ready
// synchronous active-low reset restores the initial hash and empties the buffer
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .o_cmd            (cmd),
        .i_status         (status)
    );

    sha256_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (status),
        .o_digest_word (o_digest_word)
    );
endmodule

/* dv/tb_sha256_stream_hasher_top.sv */
// self-checking testbench for the sha-256 stream hasher top level
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_top;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_byte_item;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_item;

    localparam int WATCHDOG_LIMIT = 20000;

    // round constants and initial hash values of the hash standard
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher_top dut (.*);

    always #1 i_clk = ~i_clk;

    // hash state of the predictor
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] bit_count;

    t_byte_item   pending_bytes [$];
    t_digest_item expected_words [$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    bit  in_taken = 1'b0;   // input item accepted at the last rising edge

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the buffered block, folded into the chain
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = chain;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic restart_hash();
        chain = H_INIT;
        fill = 0;
        bit_count = '0;
    endtask

    // absorb one accepted byte item; on the final item queue the digest
    task automatic hash_byte_item(t_byte_item it);
        t_digest_item d;
        if (it.byte_present) begin
            blk[fill] = it.data_byte;
            fill++;
            bit_count += 64'd8;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (!it.end_of_message) return;
        blk[fill] = 8'h80;
        fill++;
        if (fill > 56) begin
            while (fill < 64) begin
                blk[fill] = 8'h00;
                fill++;
            end
            compress();
            fill = 0;
        end
        while (fill < 56) begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = bit_count[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = chain[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            expected_words = {expected_words, d};
        end
        restart_hash();
    endtask

    function automatic t_byte_item mk(logic [7:0] b, logic p, logic e);
        t_byte_item it;
        it.data_byte = b; it.byte_present = p; it.end_of_message = e;
        return it;
    endfunction

    // queue one message of len random bytes, the last one optionally on the final item
    task automatic add_message(int len, bit absent_final, bit noise);
        for (int i = 0; i < len - (absent_final ? 0 : 1); i++) begin
            pending_bytes = {pending_bytes, mk(8'($urandom), 1'b1, 1'b0)};
            if (noise && $urandom_range(0, 9) == 0)
                pending_bytes = {pending_bytes, mk(8'($urandom), 1'b0, 1'b0)};
        end
        if (absent_final || len == 0)
            pending_bytes = {pending_bytes, mk(8'($urandom), 1'b0, 1'b1)};
        else
            pending_bytes = {pending_bytes, mk(8'($urandom), 1'b1, 1'b1)};
    endtask

    // driver: offer items at the falling edge, hold each until it is accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // item still waiting, payload held
            end else if (pending_bytes.size() > 0
                         && $urandom_range(1, 100) > send_idle_pct) begin
                i_in_valid       <= 1'b1;
                i_data_byte      <= pending_bytes[0].data_byte;
                i_byte_present   <= pending_bytes[0].byte_present;
                i_end_of_message <= pending_bytes[0].end_of_message;
                void'(pending_bytes.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off when asked
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                hold_off    <= hold_off - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
            end
        end
    end

    // monitor: predict on accepted items, check digest items, watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_digest_item exp_w;
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (i_in_valid && o_in_ready)
                hash_byte_item(mk(i_data_byte, i_byte_present, i_end_of_message));
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected digest item: word %h index %0d",
                           o_digest_word, o_word_index);
                    errors++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_digest_word !== exp_w.digest_word) begin
                        $error("digest_word expected %h got %h", exp_w.digest_word,
                               o_digest_word);
                        errors++;
                    end
                    if (o_word_index !== exp_w.word_index) begin
                        $error("word_index expected %0d got %0d", exp_w.word_index,
                               o_word_index);
                        errors++;
                    end
                    if (o_last_word !== exp_w.last_word) begin
                        $error("last_word expected %0d got %0d", exp_w.last_word,
                               o_last_word);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("** sha256_stream_hasher_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        restart_hash();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, one byte each of the extremes, pad edges
        add_message(0, 1'b1, 1'b0);
        pending_bytes = {pending_bytes, mk(8'h00, 1'b1, 1'b1)};
        pending_bytes = {pending_bytes, mk(8'hff, 1'b0, 1'b0)};
        pending_bytes = {pending_bytes, mk(8'hff, 1'b1, 1'b1)};
        add_message(3, 1'b1, 1'b0);
        add_message(55, 1'b0, 1'b0);
        add_message(56, 1'b0, 1'b0);
        add_message(64, 1'b1, 1'b0);
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 37 : 80) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 37 : 80) : 0;
            for (int m = 0; m < 3; m++) begin
                case ($urandom_range(0, 3))
                    0: add_message($urandom_range(0, 3), $urandom_range(0, 1), 1'b1);
                    1: add_message($urandom_range(54, 66), $urandom_range(0, 1), 1'b1);
                    default: add_message($urandom_range(1, 20), $urandom_range(0, 1), 1'b1);
                endcase
            end
            wait_drained();
        end

        // back pressure: sink holds off while several short messages stream in
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 400;
        for (int m = 0; m < 5; m++) add_message($urandom_range(1, 4), 1'b0, 1'b0);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("** sha256_stream_hasher_top: PASSED **");
        else
            $display("** sha256_stream_hasher_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/core/sha256_pkg.sv
rtl/core/sha256_datapath.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_stream_hasher_top.sv
dv/tb_sha256_stream_hasher_top.sv
